[rtl/core/animation_phase_generator_top_defines.svh]
// Assertion macros shared by the phase generator checker.
`ifndef ANIMATION_PHASE_GENERATOR_TOP_DEFINES_SVH
`define ANIMATION_PHASE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define APG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define APG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/apg_pkg.sv]
// Shared types and constants of the animation phase generator.
package apg_pkg;

    localparam int unsigned STEP_W  = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd2;

    localparam logic [MODE_W-1:0] WAVE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] WAVE_REPEAT   = 2'd1;
    localparam logic [MODE_W-1:0] WAVE_TRIANGLE = 2'd2;

    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd1000;
    localparam logic [MODE_W-1:0]  MODE_RESET  = WAVE_REPEAT;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd0;

    typedef struct packed {
        logic [STEP_W-1:0]  step_ms;
        logic [MODE_W-1:0]  wave_mode;
        logic [DELAY_W-1:0] delay_ms;
    } apg_cfg_t;

    typedef struct packed {
        logic busy;
        logic whole_lsb;
        logic whole_nz;
    } apg_div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_DIFF,
        ST_DIV,
        ST_DONE
    } apg_state_t;

endpackage

[rtl/core/apg_cfg_regs.sv]
// Configuration register file of the animation phase generator.
module apg_cfg_regs
    import apg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output apg_cfg_t              cfg
);

    apg_cfg_t cfg_reg;
    apg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_STEP:  cfg_next.step_ms   = wr_data[STEP_W-1:0];
                CFG_MODE:  cfg_next.wave_mode = wr_data[MODE_W-1:0];
                CFG_DELAY: cfg_next.delay_ms  = wr_data[DELAY_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ms   <= STEP_RESET;
            cfg_reg.wave_mode <= MODE_RESET;
            cfg_reg.delay_ms  <= DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/apg_div.sv]
// Bit-serial restoring divider: one quotient bit of (dividend << FRAC) / divisor a cycle.
module apg_div
    import apg_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [STEP_W-1:0]    divisor,
    output logic [FRAC_BITS-1:0] frac,
    output apg_div_stat_t        stat
);

    localparam int unsigned STEPS = TIME_BITS + FRAC_BITS;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] dvd_reg, dvd_next;
    logic [STEP_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]    dsr_reg, dsr_next;
    logic [STEPS-1:0]     q_reg, q_next;
    logic [STEP_W:0]      trial;
    logic [STEP_W:0]      diff;
    logic                 ge;

    // One shared compare-and-subtract per cycle.
    assign trial = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = !diff[STEP_W];

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        q_next   = q_reg;
        if (start)
        begin
            cnt_next = CNT_W'(STEPS);
            dvd_next = dividend;
            rem_next = '0;
            // A zero period divides as a period of one.
            dsr_next = (divisor == '0) ? STEP_W'(1) : divisor;
            q_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            dvd_next = {dvd_reg[TIME_BITS-2:0], 1'b0};
            rem_next = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
            q_next   = {q_reg[STEPS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign frac           = q_reg[FRAC_BITS-1:0];
    assign stat.busy      = (cnt_reg != '0);
    assign stat.whole_lsb = q_reg[FRAC_BITS];
    assign stat.whole_nz  = |q_reg[STEPS-1:FRAC_BITS];

endmodule

[rtl/core/animation_phase_generator_top.sv]
// Top level of the animation phase generator: sequencer, state and result register.
//
// Usage. Each input beat on in_valid/in_stall carries a millisecond timestamp
// now_ms. The first beat after reset latches the start time. The block then
// forms elapsed = now_ms - (start + delay_ms) and, when it is not negative,
// divides elapsed * 2^FRACTION_BITS by step_ms to get the new phase, shaped by
// wave_mode into a once-clamp, a sawtooth or a triangle. Each input beat gives
// exactly one output beat with factor_q16 (unsigned Q1.16) and running.
// Timing: an item passes through ST_BASE, ST_DIFF, ST_DIV and ST_DONE, where
// its result is loaded; in ST_DIV the bit-serial divider retires one quotient
// bit per cycle, and a negative elapsed time skips ST_DIV and the divider. The
// next item is accepted at the earliest on the cycle after a result is loaded.
// in_stall is high while an item is in work. The result register lets the next
// item be accepted while an earlier result still waits; if the receiver keeps
// out_stall high, the finished item waits in its last step until the register
// frees. Configuration writes are always ready and must be made while no item
// is in work. Reset clears the start latch and the held factor, empties the
// result register and loads the register defaults.
module animation_phase_generator_top
    import apg_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 16,
    parameter int unsigned TIME_BITS     = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [TIME_BITS-1:0]     now_ms,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FRACTION_BITS:0]   factor_q16,
    output logic                     running,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned FACT_W = FRACTION_BITS + 1;
    // Start plus delay needs one bit more than a timestamp; the signed
    // difference needs one more again.
    localparam int unsigned BASE_W = TIME_BITS + 1;
    localparam int unsigned DIFF_W = TIME_BITS + 2;
    localparam logic [FACT_W-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};

    apg_cfg_t      cfg;
    apg_div_stat_t div_stat;
    logic [FRACTION_BITS-1:0] div_frac;

    apg_state_t state_reg, state_next;

    logic                 started_reg, started_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [BASE_W-1:0]    base_reg, base_next;
    logic                 run_reg, run_next;
    logic [FACT_W-1:0]    held_reg, held_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FACT_W-1:0]    factor_reg, factor_next;
    logic                 running_reg, running_next;

    logic [DIFF_W-1:0]    diff;
    logic                 div_start;
    logic                 in_accept;
    logic                 out_free;
    logic [FACT_W-1:0]    frac_ext;
    logic [FACT_W-1:0]    new_factor;

    apg_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    apg_div #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRACTION_BITS)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff[TIME_BITS-1:0]),
        .divisor  (cfg.step_ms),
        .frac     (div_frac),
        .stat     (div_stat)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign diff     = {2'b00, now_reg} - {1'b0, base_reg};
    assign frac_ext = {1'b0, div_frac};

    // Shape the quotient into the new factor; a negative elapsed time or an
    // unused mode keeps the held value.
    always_comb
    begin
        new_factor = held_reg;
        if (run_reg)
        begin
            case (cfg.wave_mode)
                WAVE_ONCE:
                begin
                    if (div_stat.whole_nz)
                        new_factor = ONE_Q;
                    else if (held_reg < frac_ext)
                        new_factor = frac_ext;
                end
                WAVE_REPEAT:   new_factor = frac_ext;
                WAVE_TRIANGLE: new_factor = div_stat.whole_lsb ? (ONE_Q - frac_ext) : frac_ext;
                default:       new_factor = held_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        start_next     = start_reg;
        now_next       = now_reg;
        base_next      = base_reg;
        run_next       = run_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        factor_next    = factor_reg;
        running_next   = running_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    now_next = now_ms;
                    if (!started_reg)
                    begin
                        start_next   = now_ms;
                        started_next = 1'b1;
                    end
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                base_next  = {1'b0, start_reg} + BASE_W'(cfg.delay_ms);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                run_next = !diff[DIFF_W-1];
                if (diff[DIFF_W-1])
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_stat.busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    held_next      = new_factor;
                    factor_next    = new_factor;
                    running_next   = run_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            start_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            start_reg     <= start_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        base_reg    <= base_next;
        run_reg     <= run_next;
        factor_reg  <= factor_next;
        running_reg <= running_next;
    end

    assign out_valid  = out_valid_reg;
    assign factor_q16 = factor_reg;
    assign running    = running_reg;

endmodule

[rtl/core/apg_checker.sv]
// Port-level checker of the animation phase generator and its bind.
`include "animation_phase_generator_top_defines.svh"

module apg_checker
#(
    parameter int unsigned FRACTION_BITS = 16
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [FRACTION_BITS:0] factor_q16,
    input logic                   running
);

    // An accepted timestamp keeps the input side closed while it is in work.
    `APG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled after accept")

    // A new result only appears while an item was in work.
    `APG_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall), "result without work")

    // A valid factor never exceeds 1.0.
    `APG_ASSERT_IMP(a_factor_range, out_valid && factor_q16[FRACTION_BITS], factor_q16[FRACTION_BITS-1:0] == '0, "factor above 1.0")

    // A stalled result beat holds its contents.
    `APG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(factor_q16) && $stable(running), "stalled result changed")

endmodule

bind animation_phase_generator_top apg_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_apg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .factor_q16 (factor_q16),
    .running    (running)
);

[bench/animation_phase_generator_top_test.sv]
// Self-checking testbench of the animation phase generator: timestamp beats in, factor beats out.
module animation_phase_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import apg_pkg::*;

    // Fixed point one (1.0) of the Q1.16 factor and the unused wave mode code.
    localparam logic [16:0]          FACTOR_ONE  = 17'h10000;
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    // Register index past the end of the register list; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;
    // First timestamp after reset; it becomes the latched start time for the whole run.
    localparam logic [31:0]          START_STAMP = 32'd1000;
    // Settle wait that covers the longest item, the one through the divider.
    localparam int                   SETTLE_CYCLES = 80;
    localparam int                   SEGMENTS      = 8;
    localparam int                   SEGMENT_ITEMS = 66;

    typedef struct packed {
        logic [16:0] factor;
        logic        running;
    } phase_result_t;

    // Mirror of the block: register copies, start latch and held factor, plus the
    // queue of factors that are still owed by the block.
    class factor_scoreboard;
        logic [15:0]   step_ms;
        logic [1:0]    wave_mode;
        logic [15:0]   delay_ms;
        logic [31:0]   start_time;
        bit            started;
        logic [16:0]   held_factor;
        phase_result_t expected_q[$];
        int            mismatches;

        function new();
            step_ms     = STEP_RESET;
            wave_mode   = MODE_RESET;
            delay_ms    = DELAY_RESET;
            start_time  = '0;
            started     = 1'b0;
            held_factor = '0;
            mismatches  = 0;
        endfunction

        function void mirror_write(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_STEP:  step_ms   = data;
                CFG_MODE:  wave_mode = data[1:0];
                CFG_DELAY: delay_ms  = data;
                default:   ;
            endcase
        endfunction

        function void note_timestamp(logic [31:0] now);
            longint          elapsed;
            longint unsigned span;
            longint unsigned whole;
            longint unsigned rem;
            longint unsigned frac;
            longint unsigned fold;
            phase_result_t   res;
            if (!started)
            begin
                start_time = now;
                started    = 1'b1;
            end
            elapsed = longint'(now) - longint'(start_time) - longint'(delay_ms);
            res.running = (elapsed >= 0);
            if (elapsed >= 0)
            begin
                span  = (step_ms == 16'd0) ? 1 : step_ms;
                whole = longint'(elapsed) / span;
                rem   = longint'(elapsed) % span;
                frac  = (rem << 16) / span;
                case (wave_mode)
                    WAVE_ONCE:
                    begin
                        if (whole >= 1)
                            held_factor = FACTOR_ONE;
                        else if (held_factor < frac)
                            held_factor = frac[16:0];
                    end
                    WAVE_REPEAT:
                        held_factor = frac[16:0];
                    WAVE_TRIANGLE:
                    begin
                        fold = ((whole & 1) << 16) | frac;
                        if (fold < FACTOR_ONE)
                            held_factor = fold[16:0];
                        else
                            held_factor = 17'(18'h20000 - fold[17:0]);
                    end
                    default: ;
                endcase
            end
            res.factor = held_factor;
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_factor(logic [16:0] factor, logic run_flag);
            phase_result_t want;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected beat factor=%0d running=%0d",
                                          factor, run_flag));
            else
            begin
                want = expected_q.pop_front();
                if (factor !== want.factor)
                    report_mismatch($sformatf("factor_q16 got %0d want %0d",
                                              factor, want.factor));
                if (run_flag !== want.running)
                    report_mismatch($sformatf("running got %0d want %0d",
                                              run_flag, want.running));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [31:0]           now_ms;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [16:0]           factor_q16;
    logic                  running;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    factor_scoreboard sb;

    // Percent chance per cycle that the sender holds back a beat, and that the
    // receiver stalls. Both change only while the block is idle.
    int idle_pct;
    int stall_pct;

    // Wave mode of each random segment; every mode, including the unused one, is visited.
    logic [1:0] mode_plan [SEGMENTS] = '{WAVE_REPEAT, WAVE_ONCE, WAVE_TRIANGLE, WAVE_ONCE,
                                         WAVE_TRIANGLE, MODE_UNUSED, WAVE_REPEAT,
                                         WAVE_TRIANGLE};

    animation_phase_generator_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .factor_q16 (factor_q16),
        .running    (running),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: the stall decision is made at the falling edge, and a factor beat
    // counts at the rising edge where out_valid is high and out_stall is low.
    always
    begin
        @(negedge clk);
        out_stall = ($urandom_range(99) < stall_pct);
        @(posedge clk);
        if (rst_n && out_valid && !out_stall)
            sb.check_factor(factor_q16, running);
    end

    // Sends one timestamp beat. Random idle cycles come before the beat is raised;
    // once raised, the beat holds still until the block takes it.
    task automatic send_item(input logic [31:0] stamp);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        now_ms   = stamp;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_timestamp(stamp);
    endtask

    // Lowers the timestamp valid, waits for every owed factor and then lets the
    // block settle, so that a register write never lands on an item in work.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.mirror_write(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hard limit on the run. The slowest legal run is well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [31:0] cur;
        logic [31:0] base;
        logic [15:0] seg_step;
        logic [15:0] seg_delay;
        int          span;
        int          pick;

        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        now_ms    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEP;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, register defaults first (1000 ms sawtooth, no delay).
        // The first beat latches the start time; a repeat of it gives zero elapsed time.
        send_item(START_STAMP);
        send_item(START_STAMP);
        send_item(START_STAMP + 32'd500);
        send_item(START_STAMP + 32'd1999);
        // Time going backwards, the smallest timestamp, and the largest one.
        send_item(32'd500);
        send_item(32'd0);
        send_item(32'hFFFF_FFFF);

        // Zero step must act as a one millisecond step; triangle shows the fold at 1.0.
        wait_idle();
        write_reg(CFG_STEP, 16'd0);
        write_reg(CFG_MODE, {14'd0, WAVE_TRIANGLE});
        send_item(START_STAMP + 32'd1);
        send_item(START_STAMP + 32'd2);
        send_item(START_STAMP + 32'd3);

        // Longest step and delay in once mode: below the delay, at it, half way, further on, one full step.
        wait_idle();
        write_reg(CFG_STEP, 16'hFFFF);
        write_reg(CFG_MODE, {14'd0, WAVE_ONCE});
        write_reg(CFG_DELAY, 16'hFFFF);
        send_item(START_STAMP);
        send_item(START_STAMP + 32'd65535);
        send_item(START_STAMP + 32'd65535 + 32'd32767);
        send_item(START_STAMP + 32'd65535 + 32'd40000);
        send_item(START_STAMP + 32'd65535 + 32'd65535);

        // Oversized mode write keeps its low bits (the unused mode here, which holds
        // the factor); a write to an index past the list must change nothing.
        wait_idle();
        write_reg(CFG_MODE, 16'hFFFF);
        write_reg(CFG_NONE, 16'h0005);
        send_item(START_STAMP + 32'd70000);
        send_item(32'd10);

        // Random segments. Each one picks a register setting and an idling pattern,
        // then walks the timestamp mostly forward around the ramp so the factor
        // sweeps through its shape, with jumps, backward steps and raw noise mixed in.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            if (seg == 0)
                seg_step = 16'd1;
            else if (seg == 1)
                seg_step = 16'hFFFF;
            else if (seg == 6)
                seg_step = 16'($urandom_range(1, 65535));
            else
                seg_step = 16'($urandom_range(2, 3000));
            if (seg == 1)
                seg_delay = 16'hFFFF;
            else if (seg == 2)
                seg_delay = 16'd0;
            else if (seg == 6)
                seg_delay = 16'($urandom);
            else
                seg_delay = 16'($urandom_range(0, 3000));
            write_reg(CFG_STEP, seg_step);
            // Random upper bits on the mode write; only the low two bits count.
            write_reg(CFG_MODE, (16'($urandom) & 16'hFFFC) | {14'd0, mode_plan[seg]});
            write_reg(CFG_DELAY, seg_delay);

            case (seg % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase

            span = seg_step;
            base = START_STAMP + seg_delay;
            cur  = base - 32'($urandom_range(0, span));
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    cur = cur + 32'($urandom_range(0, span / 4 + 1));
                else if (pick < 80)
                    cur = cur + 32'($urandom_range(0, 4 * span));
                else if (pick < 88)
                    cur = base + 32'($urandom_range(0, span));
                else if (pick < 94)
                    cur = cur - 32'($urandom_range(0, span));
                else
                    cur = $urandom;
                send_item(cur);
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/apg_pkg.sv
rtl/core/apg_cfg_regs.sv
rtl/core/apg_div.sv
rtl/core/animation_phase_generator_top.sv
rtl/core/apg_checker.sv
bench/animation_phase_generator_top_test.sv
